// File: rtl/lce_pkg.sv
// Shared types, constants and the sigmoid table of the ladder combinator.
`timescale 1ns / 1ps
`default_nettype none
package lce_pkg;

   localparam int MAX_POSITIONS    = 256;
   localparam int POS_W            = $clog2(MAX_POSITIONS);
   localparam int NUM_WEIGHT_KINDS = 9;
   localparam int KIND_W           = 4;
   localparam int DATA_W           = 16;
   localparam int QUEUE_DEPTH      = 4;
   localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W           = QPTR_W + 1;
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

   typedef enum logic [KIND_W-1:0] {
      KIND_B0     = 4'd0,
      KIND_W0Z    = 4'd1,
      KIND_W0U    = 4'd2,
      KIND_W0ZU   = 4'd3,
      KIND_WSIGMA = 4'd4,
      KIND_B1     = 4'd5,
      KIND_W1Z    = 4'd6,
      KIND_W1U    = 4'd7,
      KIND_W1ZU   = 4'd8
   } kind_type;

   typedef enum logic {
      OP_WRITE   = 1'b0,
      OP_COMPUTE = 1'b1
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0]                        z;
      logic [DATA_W-1:0]                        u;
      logic [NUM_WEIGHT_KINDS-1:0][DATA_W-1:0]  w;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] used;
   } queue_status_type;

   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [255:0][7:0] sig_build();
      logic [255:0][7:0] rom;
      logic [63:0]       sq;
      logic [63:0]       e;
      logic [63:0]       den;
      logic [63:0]       val;
      logic [63:0]       neg;
      sq  = (EXP_STEP_Q32 * EXP_STEP_Q32) >> 32;
      e   = EXP_STEP_Q32;
      rom = '0;
      for (int k = 0; k < 128; k++) begin
         den = (64'd1 << 32) + e;
         val = udiv64((64'd256 << 32) + (den >> 1), den);
         neg = 64'd256 - val;
         rom[128 + k] = (val > 64'd255) ? 8'd255 : val[7:0];
         rom[127 - k] = (neg > 64'd255) ? 8'd255 : neg[7:0];
         e = (e * sq) >> 32;
      end
      return rom;
   endfunction

   localparam logic [255:0][7:0] SIG_ROM = sig_build();

endpackage
`default_nettype wire

// File: rtl/lce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: rtl/lce_front.sv
// Input side: accepts items, stores weights, reads a position's weights.
`timescale 1ns / 1ps
`default_nettype none
module lce_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [55:0]               req_tdata,
   input  wire logic [4:0]                req_tuser,
   input  wire lce_pkg::queue_status_type qstat,
   output lce_pkg::push_type              push
);

   logic                                                      accept;
   logic                                                      is_write;
   logic [lce_pkg::KIND_W-1:0]                                kind;
   logic [lce_pkg::POS_W-1:0]                                 pos;
   logic [lce_pkg::NUM_WEIGHT_KINDS-1:0][lce_pkg::DATA_W-1:0] rd;
   logic                                                      s1_valid_ff;
   logic                                                      s1_valid_in;
   logic [lce_pkg::DATA_W-1:0]                                s1_z_ff;
   logic [lce_pkg::DATA_W-1:0]                                s1_u_ff;

   assign kind     = req_tuser[4:1];
   assign pos      = req_tdata[7:0];
   assign is_write = (lce_pkg::op_type'(req_tuser[0]) == lce_pkg::OP_WRITE);
   assign accept   = req_tvalid && req_tready;

   assign req_tready = (qstat.used + lce_pkg::QCNT_W'(s1_valid_ff))
                       < lce_pkg::QCNT_W'(lce_pkg::QUEUE_DEPTH);

   for (genvar k = 0; k < lce_pkg::NUM_WEIGHT_KINDS; k++) begin : g_ram
      lce_ram #(
         .WIDTH(lce_pkg::DATA_W),
         .DEPTH(lce_pkg::MAX_POSITIONS)
      ) u_ram (
         .clock(clock),
         .we   (accept && is_write && (kind == lce_pkg::KIND_W'(k))),
         .waddr(pos),
         .wdata(req_tdata[23:8]),
         .raddr(pos),
         .rdata(rd[k])
      );
   end

   assign s1_valid_in = accept && !is_write;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_z_ff <= req_tdata[39:24];
      s1_u_ff <= req_tdata[55:40];
   end

   assign push.valid  = s1_valid_ff;
   assign push.item.z = s1_z_ff;
   assign push.item.u = s1_u_ff;
   assign push.item.w = rd;

endmodule
`default_nettype wire

// File: rtl/lce_queue.sv
// Short queue between the input side and the arithmetic pipeline.
`timescale 1ns / 1ps
`default_nettype none
module lce_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lce_pkg::push_type         push,
   output lce_pkg::queue_status_type      qstat,
   output logic                           pop_valid,
   output lce_pkg::item_type              pop_item,
   input  wire logic                      pop_take
);

   lce_pkg::item_type           mem_ff [lce_pkg::QUEUE_DEPTH];
   logic [lce_pkg::QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [lce_pkg::QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [lce_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;
   logic                        pop;

   assign pop_valid = (cnt_ff != '0);
   assign pop       = pop_valid && pop_take;
   assign pop_item  = mem_ff[rptr_ff];
   assign qstat.used = cnt_ff;

   always_comb begin
      wptr_in = push.valid ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + lce_pkg::QCNT_W'(push.valid) - lce_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push.valid) begin
         mem_ff[wptr_ff] <= push.item;
      end
   end

endmodule
`default_nettype wire

// File: rtl/lce_back.sv
// Arithmetic pipeline: products, sigmoid, rounding, saturation, output register.
`timescale 1ns / 1ps
`default_nettype none
module lce_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop_valid,
   input  wire lce_pkg::item_type pop_item,
   output logic                   pop_take,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [15:0]            rsp_tdata,
   output logic [0:0]             rsp_tuser
);

   localparam int AW = 36;
   localparam int RW = AW - 8;

   typedef logic signed [15:0] q_type;
   typedef logic signed [31:0] p_type;
   typedef logic signed [AW-1:0] acc_type;

   logic adv;

   logic  v1_ff;
   p_type zu_p_ff, p1z_ff, p1u_ff, p0z_ff, p0u_ff;
   q_type b0_1_ff, b1_1_ff, w0zu_1_ff, w1zu_1_ff, ws_1_ff;

   logic    v2_ff, f2_ff;
   q_type   zu_2_ff, w0zu_2_ff, w1zu_2_ff, ws_2_ff;
   acc_type s1_2_ff, s0_2_ff;
   logic signed [32:0]  zu_t;
   logic signed [24:0]  zu_r;
   q_type               zu_in;
   logic                f2_in;

   logic    v3_ff, f3_ff;
   p_type   q1_3_ff, q0_3_ff;
   acc_type s1_3_ff, s0_3_ff;
   q_type   ws_3_ff;

   logic    v4_ff, f4_ff;
   acc_type a1_4_ff, a0_4_ff;
   q_type   ws_4_ff;

   logic    v5_ff, f5_ff;
   logic [7:0] sig_5_ff;
   acc_type a0_5_ff;
   q_type   ws_5_ff;
   acc_type a1_t;
   logic signed [RW-1:0] arg_r;
   logic [11:0] arg_c;
   logic [11:0] biased;

   logic    v6_ff, f6_ff;
   logic signed [24:0] ps_6_ff;
   acc_type a0_6_ff;

   acc_type acc7;
   acc_type acc7_t;
   logic signed [RW-1:0] res_r;
   q_type   res_in;
   logic    flag_in;

   logic    rsp_valid_ff;
   q_type   rsp_data_ff;
   logic    rsp_flag_ff;

   assign adv      = !rsp_valid_ff || rsp_tready;
   assign pop_take = adv;

   always_comb begin
      zu_t = 33'(zu_p_ff) + 33'sd128;
      zu_r = zu_t[32:8];
      f2_in = 1'b0;
      if (zu_r > 25'sd32767) begin
         zu_in = 16'sh7fff;
         f2_in = 1'b1;
      end else if (zu_r < -25'sd32768) begin
         zu_in = -16'sh8000;
         f2_in = 1'b1;
      end else begin
         zu_in = zu_r[15:0];
      end
   end

   always_comb begin
      a1_t  = a1_4_ff + AW'(128);
      arg_r = a1_t[AW-1:8];
      if (arg_r > RW'(2047)) begin
         arg_c = 12'h7ff;
      end else if (arg_r < -RW'(2048)) begin
         arg_c = 12'h800;
      end else begin
         arg_c = arg_r[11:0];
      end
      biased = arg_c + 12'd2048;
   end

   always_comb begin
      acc7    = a0_6_ff + AW'(ps_6_ff);
      acc7_t  = acc7 + AW'(128);
      res_r   = acc7_t[AW-1:8];
      flag_in = f6_ff;
      if (res_r > RW'(32767)) begin
         res_in  = 16'sh7fff;
         flag_in = 1'b1;
      end else if (res_r < -RW'(32768)) begin
         res_in  = -16'sh8000;
         flag_in = 1'b1;
      end else begin
         res_in = res_r[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= pop_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         v6_ff        <= v5_ff;
         rsp_valid_ff <= v6_ff;
      end
      if (adv) begin
         zu_p_ff   <= q_type'(pop_item.z) * q_type'(pop_item.u);
         p1z_ff    <= q_type'(pop_item.w[lce_pkg::KIND_W1Z]) * q_type'(pop_item.z);
         p1u_ff    <= q_type'(pop_item.w[lce_pkg::KIND_W1U]) * q_type'(pop_item.u);
         p0z_ff    <= q_type'(pop_item.w[lce_pkg::KIND_W0Z]) * q_type'(pop_item.z);
         p0u_ff    <= q_type'(pop_item.w[lce_pkg::KIND_W0U]) * q_type'(pop_item.u);
         b0_1_ff   <= q_type'(pop_item.w[lce_pkg::KIND_B0]);
         b1_1_ff   <= q_type'(pop_item.w[lce_pkg::KIND_B1]);
         w0zu_1_ff <= q_type'(pop_item.w[lce_pkg::KIND_W0ZU]);
         w1zu_1_ff <= q_type'(pop_item.w[lce_pkg::KIND_W1ZU]);
         ws_1_ff   <= q_type'(pop_item.w[lce_pkg::KIND_WSIGMA]);

         zu_2_ff   <= zu_in;
         f2_ff     <= f2_in;
         s1_2_ff   <= (AW'(b1_1_ff) <<< 8) + AW'(p1z_ff) + AW'(p1u_ff);
         s0_2_ff   <= (AW'(b0_1_ff) <<< 8) + AW'(p0z_ff) + AW'(p0u_ff);
         w0zu_2_ff <= w0zu_1_ff;
         w1zu_2_ff <= w1zu_1_ff;
         ws_2_ff   <= ws_1_ff;

         q1_3_ff   <= w1zu_2_ff * zu_2_ff;
         q0_3_ff   <= w0zu_2_ff * zu_2_ff;
         s1_3_ff   <= s1_2_ff;
         s0_3_ff   <= s0_2_ff;
         f3_ff     <= f2_ff;
         ws_3_ff   <= ws_2_ff;

         a1_4_ff   <= s1_3_ff + AW'(q1_3_ff);
         a0_4_ff   <= s0_3_ff + AW'(q0_3_ff);
         f4_ff     <= f3_ff;
         ws_4_ff   <= ws_3_ff;

         sig_5_ff  <= lce_pkg::SIG_ROM[biased[11:4]];
         a0_5_ff   <= a0_4_ff;
         f5_ff     <= f4_ff;
         ws_5_ff   <= ws_4_ff;

         ps_6_ff   <= ws_5_ff * $signed({1'b0, sig_5_ff});
         a0_6_ff   <= a0_5_ff;
         f6_ff     <= f5_ff;

         rsp_data_ff <= res_in;
         rsp_flag_ff <= flag_in;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_flag_ff;

endmodule
`default_nettype wire

// File: rtl/ladder_combinator_elementwise_unit.sv
// Top level of the elementwise ladder combinator.
// Takes one item per clock while the queue has room. A write item of kind 0 to 8
// stores one Q8.8 weight in one of nine 256-entry weight RAMs (one per kind, all
// read together) and gives no result; a compute item gives its result through a
// seven-stage arithmetic pipeline behind a four-entry queue, so a stalled
// result port holds the pipeline while the input keeps taking items until the
// queue fills. A write is visible to a compute item accepted on the next cycle.
// Weights must be written before any compute item reads them.
`timescale 1ns / 1ps
`default_nettype none
module ladder_combinator_elementwise_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,  // position, weight_value, z_value, u_value
   input  wire logic [4:0]  req_tuser,  // req_type, weight_kind
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // out_value
   output logic [0:0]       rsp_tuser   // saturated
);

   lce_pkg::push_type         push;
   lce_pkg::queue_status_type qstat;
   logic                      pop_valid;
   lce_pkg::item_type         pop_item;
   logic                      pop_take;

   lce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .qstat     (qstat),
      .push      (push)
   );

   lce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .qstat    (qstat),
      .pop_valid(pop_valid),
      .pop_item (pop_item),
      .pop_take (pop_take)
   );

   lce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_item  (pop_item),
      .pop_take  (pop_take),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
`default_nettype wire

// File: rtl/lce_checker.sv
// Port-level checks of the ladder combinator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind ladder_combinator_elementwise_unit lce_checker u_lce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready)
);
`default_nettype wire

// File: dv/ladder_combinator_elementwise_unit_tb.sv
// Testbench of the ladder combinator: random weight writes and compute items, scoreboard check.
`timescale 1ns / 1ps
module ladder_combinator_elementwise_unit_tb;

   localparam int WDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [4:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   int  send_idle_pct;
   int  recv_stall_pct;
   bit  hold_off;
   int  quiet_cycles;

   typedef struct packed {
      logic [15:0] out_value;
      logic        saturated;
   } combo_result_type;

   class combo_scoreboard;
      logic [15:0]      weights [lce_pkg::NUM_WEIGHT_KINDS][lce_pkg::MAX_POSITIONS];
      bit               written [lce_pkg::NUM_WEIGHT_KINDS][lce_pkg::MAX_POSITIONS];
      logic [7:0]       sig_lut [256];
      combo_result_type pending [$];
      int               errors;

      function new();
         longint unsigned sq;
         longint unsigned e;
         longint unsigned den;
         longint unsigned val;
         longint unsigned neg;
         sq = (64'd4162825044 * 64'd4162825044) >> 32;
         e  = 64'd4162825044;
         for (int k = 0; k < 128; k++) begin
            den = (64'd1 << 32) + e;
            val = ((64'd256 << 32) + den / 2) / den;
            neg = 256 - val;
            sig_lut[128 + k] = (val > 255) ? 8'd255 : val[7:0];
            sig_lut[127 - k] = (neg > 255) ? 8'd255 : neg[7:0];
            e = (e * sq) >> 32;
         end
         errors = 0;
         foreach (written[k, p]) written[k][p] = 0;
      endfunction

      function bit loaded(int p);
         for (int k = 0; k < lce_pkg::NUM_WEIGHT_KINDS; k++) begin
            if (!written[k][p]) return 0;
         end
         return 1;
      endfunction

      function longint round_q8(longint v);
         return (v + 128) >>> 8;
      endfunction

      function longint clip16(longint v, inout bit flag);
         if (v > 32767) begin
            flag = 1;
            return 32767;
         end
         if (v < -32768) begin
            flag = 1;
            return -32768;
         end
         return v;
      endfunction

      function longint wt(lce_pkg::kind_type k, int p);
         return longint'($signed(weights[k][p]));
      endfunction

      function void note_item(logic [55:0] data, logic [4:0] user);
         lce_pkg::op_type  op;
         int               kind;
         int               p;
         longint           z;
         longint           u;
         longint           zu;
         longint           acc;
         longint           arg;
         bit               flag;
         combo_result_type r;
         op   = lce_pkg::op_type'(user[0]);
         kind = user[4:1];
         p    = data[7:0];
         if (op == lce_pkg::OP_WRITE) begin
            if (kind < lce_pkg::NUM_WEIGHT_KINDS) begin
               weights[kind][p] = data[23:8];
               written[kind][p] = 1;
            end
            return;
         end
         flag = 0;
         z    = longint'($signed(data[39:24]));
         u    = longint'($signed(data[55:40]));
         zu   = clip16(round_q8(z * u), flag);
         acc  = wt(lce_pkg::KIND_B1, p) * 256 + wt(lce_pkg::KIND_W1Z, p) * z
              + wt(lce_pkg::KIND_W1U, p) * u + wt(lce_pkg::KIND_W1ZU, p) * zu;
         arg  = round_q8(acc);
         if (arg > 2047) arg = 2047;
         if (arg < -2048) arg = -2048;
         acc  = wt(lce_pkg::KIND_WSIGMA, p) * longint'(sig_lut[(arg + 2048) >>> 4])
              + wt(lce_pkg::KIND_B0, p) * 256 + wt(lce_pkg::KIND_W0Z, p) * z
              + wt(lce_pkg::KIND_W0U, p) * u + wt(lce_pkg::KIND_W0ZU, p) * zu;
         r.out_value = 16'(clip16(round_q8(acc), flag));
         r.saturated = flag;
         pending.push_back(r);
      endfunction

      function void check_result(logic [15:0] data, logic [0:0] user);
         combo_result_type x;
         if (pending.size() == 0) begin
            $error("unexpected result out_value=%h saturated=%b", data, user);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (data !== x.out_value) begin
            $error("out_value expected %h actual %h", x.out_value, data);
            errors++;
         end
         if (user[0] !== x.saturated) begin
            $error("saturated expected %b actual %b", x.saturated, user[0]);
            errors++;
         end
      endfunction
   endclass

   combo_scoreboard board;

   ladder_combinator_elementwise_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      board = new();
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_item(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // one item; idle gaps are taken before it is offered
   task automatic send_item(lce_pkg::op_type op, int kind, int p, logic [15:0] w,
                            logic [15:0] z, logic [15:0] u);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {u, z, w, p[7:0]};
      req_tuser  <= {kind[3:0], op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_position(int p, bit extreme);
      logic [15:0] w;
      for (int k = 0; k < lce_pkg::NUM_WEIGHT_KINDS; k++) begin
         w = extreme ? (($urandom_range(1)) ? 16'h7fff : 16'h8000) : 16'($urandom);
         if (!extreme && $urandom_range(1)) w = 16'($signed(w) >>> $urandom_range(3, 8));
         send_item(lce_pkg::OP_WRITE, k, p, w, 16'($urandom), 16'($urandom));
      end
   endtask

   task automatic send_compute(int p);
      logic [15:0] z;
      logic [15:0] u;
      z = 16'($urandom);
      u = 16'($urandom);
      if ($urandom_range(2) == 0) z = 16'($signed(z) >>> $urandom_range(4, 10));
      if ($urandom_range(2) == 0) u = 16'($signed(u) >>> $urandom_range(4, 10));
      send_item(lce_pkg::OP_COMPUTE, $urandom_range(15), p, 16'($urandom), z, u);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic random_phase(int n_items);
      int p;
      for (int i = 0; i < n_items; i++) begin
         p = $urandom_range(1) ? $urandom_range(7) : 248 + $urandom_range(7);
         case ($urandom_range(9))
            0: send_item(lce_pkg::OP_WRITE, $urandom_range(9, 15), p, 16'($urandom),
                         16'($urandom), 16'($urandom));
            1, 2: send_item(lce_pkg::OP_WRITE, $urandom_range(8), p, 16'($urandom),
                            16'($urandom), 16'($urandom));
            default: begin
               if (!board.loaded(p)) load_position(p, 0);
               send_compute(p);
            end
         endcase
      end
   endtask

   initial begin
      logic [15:0] edge_vals [4];
      reset          = 1;
      req_tvalid     = 0;
      req_tdata      = '0;
      req_tuser      = '0;
      hold_off       = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      edge_vals      = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      load_position(0, 1);
      load_position(255, 0);
      for (int i = 0; i < 4; i++) begin
         send_item(lce_pkg::OP_COMPUTE, 15, 0, 16'hffff, edge_vals[i], edge_vals[3 - i]);
         send_item(lce_pkg::OP_COMPUTE, 0, 255, 16'h0, edge_vals[i], edge_vals[i]);
      end
      send_item(lce_pkg::OP_WRITE, 9, 0, 16'h1234, 16'h0, 16'h0);
      send_item(lce_pkg::OP_WRITE, 15, 0, 16'hffff, 16'hffff, 16'hffff);
      send_compute(0);
      drain();

      random_phase(100);
      send_idle_pct = 69;
      random_phase(100);
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      random_phase(100);
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      random_phase(80);

      // long receiver hold-off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fork
         begin
            hold_off <= 1;
            repeat (60) @(posedge clock);
            hold_off <= 0;
         end
         begin
            for (int i = 0; i < 20; i++) send_compute(0);
         end
      join
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/lce_pkg.sv
rtl/lce_ram.sv
rtl/lce_front.sv
rtl/lce_queue.sv
rtl/lce_back.sv
rtl/ladder_combinator_elementwise_unit.sv
rtl/lce_checker.sv
dv/ladder_combinator_elementwise_unit_tb.sv
